// ===== rtl/core/ppc_pkg.sv =====
// Shared types, register indexes and the sequencer microprogram for the PWM period calculator.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned CLK_W   = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned CMP_W   = 15;
    localparam int unsigned OPA_W   = 17;               // multiplier A operand
    localparam int unsigned DEN_W   = OPA_W + FREQ_W;   // divisor / product width
    localparam int unsigned QUO_W   = 32;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned OUT_W   = 48;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RST   = 32'd80000000;
    localparam logic [HALF_W-1:0] CLOCK_DIV_RST  = 16'd0;
    localparam logic [HALF_W-1:0] MAX_PSC_RST    = 16'hFFFF;
    localparam logic [HALF_W-1:0] MAX_PER_RST    = 16'hFFFF;

    localparam logic [CFG_AW-1:0] REG_CLOCK_HZ   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CLOCK_DIV  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MAX_PSC    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_PER    = 2'd3;

    typedef logic [3:0] step_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_DIV_BASE,
        OP_DIV_PROD,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        MS_MP1_F,   // (max_per + 1) * f
        MS_QP1_F,   // (q + 1) * f
        MS_M_F      // max_per * f
    } mul_sel_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_BASE,
        DST_Q,
        DST_PER
    } dst_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INIT,
        ACT_PSC_Q,
        ACT_PER_M,
        ACT_PSC_FB,
        ACT_PSC_SAT
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_FZERO,
        C_QGT,
        C_PZERO
    } cond_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t msel;
        dst_t     dst;
        act_t     act;
        cond_t    cond;
        step_t    target;
    } uword_t;

    localparam step_t S_FALLBACK = 4'd7;
    localparam step_t S_SAT      = 4'd11;
    localparam step_t S_DONE     = 4'd12;

    // Microprogram ROM: one control word per step.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{OP_DONE, MS_MP1_F, DST_NONE, ACT_NONE, C_NEVER, S_DONE};
        unique case (s)
            4'd0:  w = '{OP_NOP,      MS_MP1_F, DST_NONE, ACT_INIT,    C_FZERO,  S_DONE};
            4'd1:  w = '{OP_DIV_BASE, MS_MP1_F, DST_BASE, ACT_NONE,    C_NEVER,  S_DONE};
            4'd2:  w = '{OP_MUL,      MS_MP1_F, DST_NONE, ACT_NONE,    C_NEVER,  S_DONE};
            4'd3:  w = '{OP_DIV_PROD, MS_MP1_F, DST_Q,    ACT_NONE,    C_NEVER,  S_DONE};
            4'd4:  w = '{OP_NOP,      MS_MP1_F, DST_NONE, ACT_NONE,    C_QGT,    S_FALLBACK};
            4'd5:  w = '{OP_MUL,      MS_QP1_F, DST_NONE, ACT_PSC_Q,   C_NEVER,  S_DONE};
            4'd6:  w = '{OP_DIV_PROD, MS_MP1_F, DST_PER,  ACT_NONE,    C_ALWAYS, S_DONE};
            4'd7:  w = '{OP_MUL,      MS_M_F,   DST_NONE, ACT_PER_M,   C_NEVER,  S_DONE};
            4'd8:  w = '{OP_NOP,      MS_MP1_F, DST_NONE, ACT_NONE,    C_PZERO,  S_SAT};
            4'd9:  w = '{OP_DIV_PROD, MS_MP1_F, DST_Q,    ACT_NONE,    C_NEVER,  S_DONE};
            4'd10: w = '{OP_NOP,      MS_MP1_F, DST_NONE, ACT_PSC_FB,  C_ALWAYS, S_DONE};
            4'd11: w = '{OP_NOP,      MS_MP1_F, DST_NONE, ACT_PSC_SAT, C_NEVER,  S_DONE};
            default: w = '{OP_DONE,   MS_MP1_F, DST_NONE, ACT_NONE,    C_NEVER,  S_DONE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/pwm_prescaler_period_calc_top.sv =====
// Top level of the PWM prescaler / period calculator: sequencer, datapath and ports.
`timescale 1ns / 1ps

//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+-----------------------------------------
//  s_        | in        | s_tvalid / s_tready   | s_tdata[31:0] frequency
//  m_        | out       | m_tvalid / m_tready   | m_tdata ok, prescaler, period, compare
//  cfg_      | in        | cfg_wr_en (no wait)   | cfg_addr register index, cfg_wdata value
//
//  Sequence: a zero frequency skips the divider and goes from accept straight to the result;
//  a regular item goes through the shared restoring divider up to three times (once less when
//  the period clamp finds a zero product), the sequencer walking the microprogram one step at
//  a time.
//  Reset: aresetn is synchronous and active low; it restores the register defaults,
//  parks the sequencer at idle and empties the output register.
//  Stalls: a finished result waits in the output register while s_tready is high
//  again; for the output, the sequencer waits only at its final step, while the previous result is still held.

module pwm_prescaler_period_calc_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // frequency[31:0]
    input  logic [ppc_pkg::FREQ_W-1:0]       s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ok[0], prescaler[16:1], period[32:17], compare[47:33]
    output logic [ppc_pkg::OUT_W-1:0]        m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [ppc_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [ppc_pkg::CLK_W-1:0]        cfg_wdata
);

    // configuration registers
    logic [ppc_pkg::CLK_W-1:0]  tclk_hz_reg;
    logic [ppc_pkg::HALF_W-1:0] tclk_div_reg;
    logic [ppc_pkg::HALF_W-1:0] max_psc_reg;
    logic [ppc_pkg::HALF_W-1:0] max_per_reg;

    // control
    ppc_pkg::state_t state_reg, state_next;
    ppc_pkg::step_t  step_reg, step_next;
    ppc_pkg::uword_t uw;
    logic            seq_run;
    logic            step_done;
    logic            cond_true;
    logic            out_free;
    logic            out_load;

    // datapath
    logic [ppc_pkg::FREQ_W-1:0] f_reg;
    logic [ppc_pkg::CLK_W-1:0]  base_reg;
    logic [ppc_pkg::QUO_W-1:0]  q_reg;
    logic [ppc_pkg::DEN_W-1:0]  prod_reg;
    logic [ppc_pkg::HALF_W-1:0] psc_reg;
    logic [ppc_pkg::HALF_W-1:0] per_reg;
    logic                       ok_reg;
    logic [ppc_pkg::OPA_W-1:0]  mul_a;
    logic [ppc_pkg::QUO_W-1:0]  q_m1;
    logic [ppc_pkg::HALF_W-1:0] psc_fb;

    // divider
    logic                       div_busy_reg;
    logic                       div_done_reg;
    logic [ppc_pkg::CNT_W-1:0]  div_cnt_reg;
    logic [ppc_pkg::QUO_W-1:0]  dvd_reg;        // dividend in, quotient out
    logic [ppc_pkg::DEN_W-1:0]  den_reg;
    logic [ppc_pkg::DEN_W-1:0]  rem_reg;
    logic [ppc_pkg::DEN_W:0]    trial;
    logic                       trial_ge;
    logic                       div_op;
    logic                       div_start;

    logic                       m_tvalid_reg;
    logic [ppc_pkg::OUT_W-1:0]  m_tdata_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tclk_hz_reg   <= ppc_pkg::CLOCK_HZ_RST;
            tclk_div_reg  <= ppc_pkg::CLOCK_DIV_RST;
            max_psc_reg   <= ppc_pkg::MAX_PSC_RST;
            max_per_reg   <= ppc_pkg::MAX_PER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ppc_pkg::REG_CLOCK_HZ:  tclk_hz_reg   <= cfg_wdata;
                ppc_pkg::REG_CLOCK_DIV: tclk_div_reg  <= cfg_wdata[ppc_pkg::HALF_W-1:0];
                ppc_pkg::REG_MAX_PSC:   max_psc_reg   <= cfg_wdata[ppc_pkg::HALF_W-1:0];
                ppc_pkg::REG_MAX_PER:   max_per_reg   <= cfg_wdata[ppc_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- sequencer
    assign uw       = ppc_pkg::ucode(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign div_op   = (uw.op == ppc_pkg::OP_DIV_BASE) || (uw.op == ppc_pkg::OP_DIV_PROD);

    // a step retires at once, except a division (wait for the divider) and the
    // final step (wait for room in the output register)
    always_comb begin
        case (uw.op) inside
            ppc_pkg::OP_DIV_BASE,
            ppc_pkg::OP_DIV_PROD: step_done = div_done_reg;
            ppc_pkg::OP_DONE:     step_done = out_free;
            default:              step_done = 1'b1;
        endcase
    end

    always_comb begin
        case (uw.cond)
            ppc_pkg::C_ALWAYS: cond_true = 1'b1;
            ppc_pkg::C_FZERO:  cond_true = (f_reg == '0);
            ppc_pkg::C_QGT:    cond_true = (q_reg > {{(ppc_pkg::QUO_W-ppc_pkg::HALF_W){1'b0}},
                                                     max_psc_reg});
            ppc_pkg::C_PZERO:  cond_true = (prod_reg == '0);
            default:           cond_true = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppc_pkg::ST_IDLE: if (s_tvalid) state_next = ppc_pkg::ST_RUN;
            ppc_pkg::ST_RUN:  if (uw.op == ppc_pkg::OP_DONE && step_done)
                                  state_next = ppc_pkg::ST_IDLE;
            default:          state_next = ppc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        seq_run  = 1'b0;
        unique case (state_reg)
            ppc_pkg::ST_IDLE: s_tready = 1'b1;
            ppc_pkg::ST_RUN:  seq_run  = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        if (!seq_run) begin
            step_next = '0;
        end else if (step_done) begin
            step_next = cond_true ? uw.target : step_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppc_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // -------------------------------------------------------------- datapath
    always_comb begin
        case (uw.msel)
            ppc_pkg::MS_QP1_F: mul_a = {1'b0, q_reg[ppc_pkg::HALF_W-1:0]} + 17'd1;
            ppc_pkg::MS_M_F:   mul_a = {1'b0, max_per_reg};
            default:           mul_a = {1'b0, max_per_reg} + 17'd1;
        endcase
    end

    // fallback prescaler: q - 1, floored at zero, clamped to max_psc
    assign q_m1 = q_reg - 32'd1;
    always_comb begin
        if (q_reg == '0) begin
            psc_fb = '0;
        end else if (q_m1 > {{(ppc_pkg::QUO_W-ppc_pkg::HALF_W){1'b0}}, max_psc_reg}) begin
            psc_fb = max_psc_reg;
        end else begin
            psc_fb = q_m1[ppc_pkg::HALF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            f_reg <= s_tdata;
        end
        if (seq_run && uw.op == ppc_pkg::OP_MUL) begin
            prod_reg <= {{(ppc_pkg::DEN_W-ppc_pkg::OPA_W){1'b0}}, mul_a}
                      * {{(ppc_pkg::DEN_W-ppc_pkg::FREQ_W){1'b0}}, f_reg};
        end
        if (seq_run && step_done) begin
            case (uw.act)
                ppc_pkg::ACT_INIT: begin
                    ok_reg  <= (f_reg != '0);
                    psc_reg <= '0;
                    per_reg <= '0;
                end
                ppc_pkg::ACT_PSC_Q:   psc_reg <= q_reg[ppc_pkg::HALF_W-1:0];
                ppc_pkg::ACT_PER_M:   per_reg <= max_per_reg;
                ppc_pkg::ACT_PSC_FB:  psc_reg <= psc_fb;
                ppc_pkg::ACT_PSC_SAT: psc_reg <= max_psc_reg;
                default: ;
            endcase
            case (uw.dst)
                ppc_pkg::DST_BASE: base_reg <= dvd_reg;
                ppc_pkg::DST_Q:    q_reg    <= dvd_reg;
                ppc_pkg::DST_PER:  per_reg  <= dvd_reg[ppc_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------- restoring divider, 1 bit/cycle
    assign div_start = seq_run && div_op && !div_busy_reg && !div_done_reg;
    assign trial     = {rem_reg, dvd_reg[ppc_pkg::QUO_W-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (div_start) begin
            rem_reg <= '0;
            if (uw.op == ppc_pkg::OP_DIV_BASE) begin
                dvd_reg <= tclk_hz_reg;
                den_reg <= {{(ppc_pkg::DEN_W-ppc_pkg::OPA_W){1'b0}},
                            ({1'b0, tclk_div_reg} + 17'd1)};
            end else begin
                dvd_reg <= base_reg;
                den_reg <= prod_reg;
            end
        end else if (div_busy_reg) begin
            rem_reg <= trial_ge ? (trial[ppc_pkg::DEN_W-1:0] - den_reg)
                                : trial[ppc_pkg::DEN_W-1:0];
            dvd_reg <= {dvd_reg[ppc_pkg::QUO_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (div_cnt_reg == {ppc_pkg::CNT_W{1'b1}}) begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end else if (div_done_reg && seq_run && div_op) begin
            // quotient is committed this cycle; clear for the next division
            div_done_reg <= 1'b0;
        end
    end

    // --------------------------------------------------------- output register
    assign out_load = seq_run && uw.op == ppc_pkg::OP_DONE && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {per_reg[ppc_pkg::HALF_W-1:1], per_reg, psc_reg, ok_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/ppc_checker.sv =====
// Port-level checker for the PWM period calculator, bound to the top level.
`timescale 1ns / 1ps

module ppc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ppc_pkg::OUT_W-1:0]   m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // compare is half the period
    a_half: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:33] == m_tdata[32:18])
        else $error("compare is not half of period");

    // a rejected request carries zeroed fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[47:1] == '0)
        else $error("nonzero fields with ok low");

endmodule

bind pwm_prescaler_period_calc_top ppc_checker u_ppc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
